@@ src/dcsg_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the disc cost stamp grid
// no dependencies

package dcsg_pkg;

	localparam int GRID_W     = 64;
	localparam int GRID_H     = 64;
	localparam int GRID_CELLS = GRID_W * GRID_H;
	localparam int ADDR_W     = $clog2(GRID_CELLS);
	localparam int X_W        = 6;
	localparam int Y_W        = 6;
	localparam int COST_W     = 8;
	localparam int WIN_W      = 7;
	localparam int RAD_W      = 4;
	localparam int MAX_RADIUS = 15;
	localparam int DELTA_W    = 5;
	localparam int COORD_W    = 8;
	localparam int COUNT_W    = 10;
	localparam int MODE_W     = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 24;

	localparam logic [COST_W-1:0]  UNKNOWN_COST = 8'd255;
	localparam logic [COUNT_W-1:0] COUNT_MAX    = 10'd1023;

	localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_STAMP = 2'd1;
	localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_X  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_Y  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_END_X  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_END_Y  = 3'd5;

	typedef struct packed {
		logic             enable;
		logic [RAD_W-1:0] radius;
		logic [WIN_W-1:0] low_x;
		logic [WIN_W-1:0] low_y;
		logic [WIN_W-1:0] end_x;
		logic [WIN_W-1:0] end_y;
	} cfg_t;

	typedef struct packed {
		logic clear_wr;
		logic capture;
		logic load_wr;
		logic scan_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic clearing;
		logic scan_last;
		logic out_free;
	} sts_t;

endpackage

@@ src/disc_cost_stamp_grid.sv @@
`timescale 1ns / 1ps
// Disc cost stamp grid. Holds a 64 by 64 grid of 8-bit costs in one memory
// with a write port and a registered read port. After reset the block sweeps
// the memory to 255 (unknown), one cell a cycle, and takes no item meanwhile;
// configuration writes are taken at all times. A load item writes its cost in
// the LOAD state and a read item reads its cell in the READ state; either then
// waits in the RESULT state until the output register is free. With stamping
// enabled, a stamp scans the (2r+1) by (2r+1) square round the centre one cell
// a cycle, a pace set by the single memory read port, through a read, compare
// and write pipeline, drains it in the FLUSH1 and FLUSH2 states and then waits
// in the RESULT state like the others. A disabled stamp or an unknown mode goes
// straight to the RESULT state.
// One item is worked on at a time; a finished result waits in the output
// register while the next item is accepted.

module disc_cost_stamp_grid (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// cell_x [5:0], cell_y [11:6], cost_value [19:12], zero fill
	input  logic [dcsg_pkg::IN_DATA_W-1:0]         s_axis_tdata,
	// mode [1:0]
	input  logic [dcsg_pkg::MODE_W-1:0]            s_axis_tuser,
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// read_cost [7:0], cells_touched [17:8], zero fill
	output logic [dcsg_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [dcsg_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [dcsg_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import dcsg_pkg::*;

	cfg_t cfg_q;
	cmd_t cmd;
	sts_t sts;

	logic [COST_W-1:0]  read_cost;
	logic [COUNT_W-1:0] touched;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable <= 1'b1;
			cfg_q.radius <= RAD_W'(9);
			cfg_q.low_x  <= '0;
			cfg_q.low_y  <= '0;
			cfg_q.end_x  <= WIN_W'(GRID_W);
			cfg_q.end_y  <= WIN_W'(GRID_H);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ENABLE: cfg_q.enable <= cfg_data[0];
				REG_RADIUS: cfg_q.radius <= cfg_data[RAD_W-1:0];
				REG_LOW_X:  cfg_q.low_x  <= cfg_data[WIN_W-1:0];
				REG_LOW_Y:  cfg_q.low_y  <= cfg_data[WIN_W-1:0];
				REG_END_X:  cfg_q.end_x  <= cfg_data[WIN_W-1:0];
				REG_END_Y:  cfg_q.end_y  <= cfg_data[WIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	dcsg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_mode  (s_axis_tuser),
		.stamp_en (cfg_q.enable),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dcsg_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.cmd           (cmd),
		.sts           (sts),
		.in_mode       (s_axis_tuser),
		.in_x          (s_axis_tdata[X_W-1:0]),
		.in_y          (s_axis_tdata[X_W+Y_W-1:X_W]),
		.in_cost       (s_axis_tdata[X_W+Y_W+COST_W-1:X_W+Y_W]),
		.out_ready     (m_axis_tready),
		.out_valid     (m_axis_tvalid),
		.out_read_cost (read_cost),
		.out_touched   (touched)
	);

	assign m_axis_tdata = {{(OUT_DATA_W-COUNT_W-COST_W){1'b0}}, touched, read_cost};

`ifndef SYNTHESIS
	// no item is taken during the clearing sweep
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		sts.clearing |-> !s_axis_tready)
		else $error("item accepted during clearing sweep");

	// an accepted item keeps the controller busy in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input ready straight after acceptance");

	// a result is loaded only when the output register is free
	a_out_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result register overwritten");

	// no stamp can touch more cells than the largest scan square holds
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[17:8] <= 10'd961))
		else $error("cell count out of range");
`endif

endmodule

@@ src/dcsg_ctrl.sv @@
`timescale 1ns / 1ps
// controller state machine for the disc cost stamp grid
// depends on dcsg_pkg

module dcsg_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [dcsg_pkg::MODE_W-1:0] in_mode,
	input  logic                  stamp_en,
	output logic                  in_ready,
	input  dcsg_pkg::sts_t        sts,
	output dcsg_pkg::cmd_t        cmd
);
	import dcsg_pkg::*;

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_LOAD   = 3'd2;
	localparam logic [2:0] ST_READ   = 3'd3;
	localparam logic [2:0] ST_SCAN   = 3'd4;
	localparam logic [2:0] ST_FLUSH1 = 3'd5;
	localparam logic [2:0] ST_FLUSH2 = 3'd6;
	localparam logic [2:0] ST_RESULT = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (sts.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					case (in_mode)
						MODE_LOAD:  state_d = ST_LOAD;
						MODE_STAMP: state_d = stamp_en ? ST_SCAN : ST_RESULT;
						MODE_READ:  state_d = ST_READ;
						default:    state_d = ST_RESULT;
					endcase
				end
			end
			ST_LOAD: begin
				cmd.load_wr = 1'b1;
				state_d     = ST_RESULT;
			end
			ST_READ: begin
				state_d = ST_RESULT;
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_FLUSH1;
				end
			end
			ST_FLUSH1: begin
				state_d = ST_FLUSH2;
			end
			ST_FLUSH2: begin
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ src/dcsg_dp.sv @@
`timescale 1ns / 1ps
// datapath: cost grid memory, disc scan counters, update pipeline, result register
// depends on dcsg_pkg

module dcsg_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  dcsg_pkg::cfg_t                 cfg,
	input  dcsg_pkg::cmd_t                 cmd,
	output dcsg_pkg::sts_t                 sts,
	input  logic [dcsg_pkg::MODE_W-1:0]    in_mode,
	input  logic [dcsg_pkg::X_W-1:0]       in_x,
	input  logic [dcsg_pkg::Y_W-1:0]       in_y,
	input  logic [dcsg_pkg::COST_W-1:0]    in_cost,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic [dcsg_pkg::COST_W-1:0]    out_read_cost,
	output logic [dcsg_pkg::COUNT_W-1:0]   out_touched
);
	import dcsg_pkg::*;

	logic [COST_W-1:0] grid_mem [GRID_CELLS];

	logic [ADDR_W-1:0]  clr_addr_q;
	logic [MODE_W-1:0]  mode_q;
	logic [X_W-1:0]     cx_q;
	logic [Y_W-1:0]     cy_q;
	logic [COST_W-1:0]  cost_q;
	logic [ADDR_W-1:0]  item_addr;

	logic [RAD_W-1:0]          r;
	logic [2*RAD_W-1:0]        r2;
	logic signed [DELTA_W-1:0] r_pos;
	logic signed [DELTA_W-1:0] r_neg;
	logic signed [DELTA_W-1:0] di_q;
	logic signed [DELTA_W-1:0] dj_q;

	logic signed [2*DELTA_W-1:0] di_sq;
	logic signed [2*DELTA_W-1:0] dj_sq;
	logic signed [2*DELTA_W:0]   dist2;
	logic signed [COORD_W-1:0]   ci;
	logic signed [COORD_W-1:0]   cj;
	logic [WIN_W-1:0]            ex;
	logic [WIN_W-1:0]            ey;
	logic                        in_disc;
	logic                        in_win;

	logic              valid_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic              valid_s2;
	logic [ADDR_W-1:0] addr_s2;
	logic [COST_W-1:0] rdata_q;
	logic [ADDR_W-1:0] rd_addr;
	logic [COUNT_W-1:0] cnt_q;

	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [COST_W-1:0] wr_data;
	logic              upd;

	logic              out_valid_q;
	logic [COST_W-1:0]  out_cost_q;
	logic [COUNT_W-1:0] out_cnt_q;

	// radius clamp and window clipping
	assign r     = (cfg.radius > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : cfg.radius;
	assign r2    = (2*RAD_W)'(r) * (2*RAD_W)'(r);
	assign r_pos = $signed({1'b0, r});
	assign r_neg = -r_pos;
	assign ex    = (cfg.end_x > WIN_W'(GRID_W)) ? WIN_W'(GRID_W) : cfg.end_x;
	assign ey    = (cfg.end_y > WIN_W'(GRID_H)) ? WIN_W'(GRID_H) : cfg.end_y;

	assign item_addr = ADDR_W'(cy_q) * ADDR_W'(GRID_W) + ADDR_W'(cx_q);

	// cell under the scan counters
	assign di_sq   = di_q * di_q;
	assign dj_sq   = dj_q * dj_q;
	assign dist2   = {1'b0, di_sq} + {1'b0, dj_sq};
	assign in_disc = (dist2 <= $signed({3'b000, r2}));
	assign ci      = $signed({2'b00, cx_q}) + COORD_W'(di_q);
	assign cj      = $signed({2'b00, cy_q}) + COORD_W'(dj_q);
	assign in_win  = (ci >= $signed({1'b0, cfg.low_x})) && (ci < $signed({1'b0, ex}))
	              && (cj >= $signed({1'b0, cfg.low_y})) && (cj < $signed({1'b0, ey}));

	assign sts.scan_last  = (di_q == r_pos) && (dj_q == r_pos);
	assign sts.clear_last = (clr_addr_q == ADDR_W'(GRID_CELLS - 1));
	assign sts.clearing   = cmd.clear_wr;
	assign sts.out_free   = !out_valid_q || out_ready;

	// item capture and scan counters
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= in_mode;
			cx_q   <= in_x;
			cy_q   <= in_y;
			cost_q <= in_cost;
			di_q   <= r_neg;
			dj_q   <= r_neg;
		end else if (cmd.scan_step) begin
			if (di_q == r_pos) begin
				di_q <= r_neg;
				dj_q <= dj_q + DELTA_W'(1);
			end else begin
				di_q <= di_q + DELTA_W'(1);
			end
		end
	end

	// update pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			clr_addr_q <= '0;
			cnt_q      <= '0;
		end else begin
			valid_s1 <= cmd.scan_step && in_disc && in_win;
			valid_s2 <= valid_s1;
			if (cmd.clear_wr) begin
				clr_addr_q <= clr_addr_q + ADDR_W'(1);
			end
			if (cmd.capture) begin
				cnt_q <= '0;
			end else if (cmd.scan_step && in_disc && in_win && cnt_q != COUNT_MAX) begin
				cnt_q <= cnt_q + COUNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= ADDR_W'(cj) * ADDR_W'(GRID_W) + ADDR_W'(ci);
		addr_s2 <= addr_s1;
	end

	// grid memory: one write and one read port
	assign rd_addr = valid_s1 ? addr_s1 : item_addr;
	assign upd     = (rdata_q == UNKNOWN_COST) || (cost_q > rdata_q);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = item_addr;
		wr_data = cost_q;
		if (cmd.clear_wr) begin
			wr_en   = 1'b1;
			wr_addr = clr_addr_q;
			wr_data = UNKNOWN_COST;
		end else if (cmd.load_wr) begin
			wr_en = 1'b1;
		end else if (valid_s2 && upd) begin
			wr_en   = 1'b1;
			wr_addr = addr_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			grid_mem[wr_addr] <= wr_data;
		end
		rdata_q <= grid_mem[rd_addr];
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_cost_q <= (mode_q == MODE_READ) ? rdata_q : '0;
			out_cnt_q  <= cnt_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_read_cost = out_cost_q;
	assign out_touched   = out_cnt_q;

endmodule
